[rtl/bbt_pkg.sv]
// ----------------------------------------------------------------------------
// bbt_pkg
// Shared constants, codes and helpers of the billboard basis transform.
// ----------------------------------------------------------------------------
package bbt_pkg;

  // alignment modes
  localparam logic [1:0] MODE_SCREEN = 2'd0;
  localparam logic [1:0] MODE_WORLD  = 2'd1;
  localparam logic [1:0] MODE_AXIS   = 2'd2;
  localparam logic [1:0] MODE_IDENT  = 2'd3;

  // register indexes
  localparam logic [1:0] REG_ALIGN   = 2'd0;
  localparam logic [1:0] REG_SCALE_X = 2'd1;
  localparam logic [1:0] REG_SCALE_Y = 2'd2;
  localparam logic [1:0] REG_SCALE_Z = 2'd3;

  localparam int VAL_W     = 32;          // Q16.16 value
  localparam int NORM_W    = 34;          // signed vector component into normaliser
  localparam int MAG_W     = 30;          // normalised magnitude width
  localparam int NORM_TOP  = MAG_W - 1;   // target msb position
  localparam int SUM_W     = 2 * MAG_W + 2;
  localparam int SQ_STEPS  = MAG_W + 1;   // result bits of the square root
  localparam int LEN_W     = SQ_STEPS;
  localparam int DIV_STEPS = 17;          // quotient bits, quotient <= 1.0
  localparam int NUM_W     = MAG_W + 17;
  localparam int NQ_W      = DIV_STEPS + 1;
  localparam int NORM_LAT  = 6 + SQ_STEPS + 1 + DIV_STEPS + 1;

  localparam logic signed [VAL_W-1:0] Q_ONE = 32'sd65536;
  localparam logic signed [VAL_W-1:0] SCALE_RESET = 32'sd65536;

  function automatic logic [5:0] lead_pos(input logic [NORM_W-1:0] v);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < NORM_W; i++)
      if (v[i]) p = 6'(i);
    return p;
  endfunction

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [47:0] v);
    if (v > 48'sd2147483647) return 32'sh7fffffff;
    if (v < -48'sd2147483648) return 32'sh80000000;
    return v[VAL_W-1:0];
  endfunction

endpackage

[rtl/bbt_norm.sv]
// ----------------------------------------------------------------------------
// bbt_norm
// Pipelined Q16.16 vector normaliser: magnitude, range shift, squares,
// bit-per-stage square root, bit-per-stage division of each component.
// ----------------------------------------------------------------------------
module bbt_norm import bbt_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [NORM_W-1:0] v [3],
  output logic signed [NQ_W-1:0]   o [3]
);

  typedef struct packed {
    logic [2:0][MAG_W-1:0] m;
    logic [2:0]            sg;
    logic                  zero;
  } side_t;

  typedef struct packed {
    logic [2:0] sg;
    logic       zero;
  } sgn_t;

  // stage A..D: magnitude, maximum, shift amount, shift
  logic [NORM_W-1:0] mag_a [3];
  logic [NORM_W-1:0] mag_b [3];
  logic [NORM_W-1:0] mag_c [3];
  logic [2:0]        sg_a, sg_b, sg_c, sg_d;
  logic [NORM_W-1:0] mx_b;
  logic              zero_c, zero_d;
  logic              rsh_c;
  logic [4:0]        amt_c;
  logic [5:0]        lp;
  logic [MAG_W-1:0]  m_d [3];

  assign lp = lead_pos(mx_b);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag_a[i] <= v[i][NORM_W-1] ? NORM_W'(-v[i]) : NORM_W'(v[i]);
        sg_a[i]  <= v[i][NORM_W-1];
      end
      mag_b <= mag_a;
      sg_b  <= sg_a;
      mx_b  <= (mag_a[0] > mag_a[1])
               ? ((mag_a[0] > mag_a[2]) ? mag_a[0] : mag_a[2])
               : ((mag_a[1] > mag_a[2]) ? mag_a[1] : mag_a[2]);
      mag_c  <= mag_b;
      sg_c   <= sg_b;
      zero_c <= (mx_b == '0);
      rsh_c  <= (lp > 6'(NORM_TOP));
      amt_c  <= (lp > 6'(NORM_TOP)) ? 5'(lp - 6'(NORM_TOP)) : 5'(6'(NORM_TOP) - lp);
      for (int i = 0; i < 3; i++)
        m_d[i] <= rsh_c ? MAG_W'(mag_c[i] >> amt_c) : MAG_W'(mag_c[i] << amt_c);
      sg_d   <= sg_c;
      zero_d <= zero_c;
    end
  end

  // stage E, F: squares and their sum
  logic [2*MAG_W-1:0] sq_e [3];
  side_t              side_e, side_f;
  logic [SUM_W-1:0]   sum_f;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_e[i]      <= m_d[i] * m_d[i];
        side_e.m[i]  <= m_d[i];
      end
      side_e.sg   <= sg_d;
      side_e.zero <= zero_d;
      sum_f  <= SUM_W'(sq_e[0]) + SUM_W'(sq_e[1]) + SUM_W'(sq_e[2]);
      side_f <= side_e;
    end
  end

  // square root, one result bit a stage
  logic [SUM_W-1:0] sx [SQ_STEPS];
  logic [SUM_W-1:0] sr [SQ_STEPS];
  side_t            ss [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * (SQ_STEPS - 1 - k));
    logic [SUM_W-1:0] x_in, r_in, trial;
    side_t            s_in;
    if (k == 0) begin : g_first
      assign x_in = sum_f;
      assign r_in = '0;
      assign s_in = side_f;
    end else begin : g_next
      assign x_in = sx[k-1];
      assign r_in = sr[k-1];
      assign s_in = ss[k-1];
    end
    assign trial = r_in + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (x_in >= trial) begin
          sx[k] <= x_in - trial;
          sr[k] <= (r_in >> 1) + BIT;
        end else begin
          sx[k] <= x_in;
          sr[k] <= r_in >> 1;
        end
        ss[k] <= s_in;
      end
    end
  end

  // stage G: numerators with half divisor for rounding
  logic [NUM_W-1:0] num_g [3];
  logic [LEN_W-1:0] len_g, len_s;
  sgn_t             sg_g;

  assign len_s = sr[SQ_STEPS-1][LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++)
        num_g[i] <= (NUM_W'(ss[SQ_STEPS-1].m[i]) << 16) + NUM_W'(len_s >> 1);
      len_g        <= len_s;
      sg_g.sg      <= ss[SQ_STEPS-1].sg;
      sg_g.zero    <= ss[SQ_STEPS-1].zero;
    end
  end

  // restoring division, one quotient bit a stage
  logic [NUM_W-1:0]     drem [DIV_STEPS][3];
  logic [DIV_STEPS-1:0] dq   [DIV_STEPS][3];
  logic [LEN_W-1:0]     dden [DIV_STEPS];
  sgn_t                 dsg  [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int SH = DIV_STEPS - 1 - j;
    logic [NUM_W-1:0]     r_in [3];
    logic [DIV_STEPS-1:0] q_in [3];
    logic [LEN_W-1:0]     d_in;
    sgn_t                 s_in;
    logic [NUM_W-1:0]     dv;
    if (j == 0) begin : g_first
      assign r_in = num_g;
      assign q_in = '{default: '0};
      assign d_in = len_g;
      assign s_in = sg_g;
    end else begin : g_next
      assign r_in = drem[j-1];
      assign q_in = dq[j-1];
      assign d_in = dden[j-1];
      assign s_in = dsg[j-1];
    end
    assign dv = NUM_W'(d_in) << SH;
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (r_in[i] >= dv) begin
            drem[j][i] <= r_in[i] - dv;
            dq[j][i]   <= q_in[i] | (DIV_STEPS'(1) << SH);
          end else begin
            drem[j][i] <= r_in[i];
            dq[j][i]   <= q_in[i];
          end
        end
        dden[j] <= d_in;
        dsg[j]  <= s_in;
      end
    end
  end

  // stage H: sign, zero vector
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (dsg[DIV_STEPS-1].zero)
          o[i] <= '0;
        else if (dsg[DIV_STEPS-1].sg[i])
          o[i] <= -$signed(NQ_W'(dq[DIV_STEPS-1][i]));
        else
          o[i] <= $signed(NQ_W'(dq[DIV_STEPS-1][i]));
      end
    end
  end

endmodule

[rtl/billboard_basis_transform.sv]
// ----------------------------------------------------------------------------
// billboard_basis_transform
// Scaled right, up and facing columns plus translation of a billboard.
// ----------------------------------------------------------------------------
//  channel | direction | beat contents
//  s_*     | in        | camera xyz, up xyz, pos xyz (32 bit each)
//  m_*     | out       | right, upcol, face, trans xyz (32 bit each)
//  cfg_*   | in        | register index, write data
//
//  One beat in and one beat out per cycle while m_tready does not stall; the
//  pipeline holds two normalisers (31-stage square root, 17-stage divider each).
//  Reset clears the valid bits and loads the register defaults.
//  A stall on m_tready freezes the whole pipeline and drops s_tready.
// ----------------------------------------------------------------------------
module billboard_basis_transform import bbt_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // camera_x, camera_y, camera_z, up_x, up_y, up_z, pos_x, pos_y, pos_z
  input  logic [287:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // right_x/y/z, upcol_x/y/z, face_x/y/z, trans_x/y/z
  output logic [383:0] m_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int TOT = 2 + NORM_LAT + 2 + NORM_LAT + 4;

  logic [1:0]              align_mode;
  logic signed [VAL_W-1:0] scale_x, scale_y, scale_z;
  logic [TOT-1:0]          vld;
  logic                    en;

  assign cfg_ready = 1'b1;
  assign en        = !vld[TOT-1] || m_tready;
  assign s_tready  = en;
  assign m_tvalid  = vld[TOT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      align_mode <= MODE_SCREEN;
      scale_x    <= SCALE_RESET;
      scale_y    <= SCALE_RESET;
      scale_z    <= SCALE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ALIGN:   align_mode <= cfg_data[1:0];
        REG_SCALE_X: scale_x    <= cfg_data;
        REG_SCALE_Y: scale_y    <= cfg_data;
        REG_SCALE_Z: scale_z    <= cfg_data;
        default:     align_mode <= align_mode;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst)     vld <= '0;
    else if (en) vld <= {vld[TOT-2:0], s_tvalid};
  end

  // stage 0, 1: capture, direction to camera
  logic signed [VAL_W-1:0]  c0 [3], u0 [3], p0 [3], u1 [3], p1 [3];
  logic signed [NORM_W-1:0] d1 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        c0[i] <= s_tdata[32*i +: 32];
        u0[i] <= s_tdata[96 + 32*i +: 32];
        p0[i] <= s_tdata[192 + 32*i +: 32];
        d1[i] <= NORM_W'(c0[i]) - NORM_W'(p0[i]);
      end
      if (align_mode == MODE_AXIS) d1[1] <= '0;
      u1 <= u0;
      p1 <= p0;
    end
  end

  // first normaliser: facing direction
  logic signed [NQ_W-1:0]  n1 [3];
  logic signed [VAL_W-1:0] dl1_up [NORM_LAT][3];
  logic signed [VAL_W-1:0] dl1_p  [NORM_LAT][3];

  bbt_norm u_norm_face (
    .clk (clk),
    .en  (en),
    .v   (d1),
    .o   (n1)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      dl1_up[0] <= u1;
      dl1_p[0]  <= p1;
      for (int k = 1; k < NORM_LAT; k++) begin
        dl1_up[k] <= dl1_up[k-1];
        dl1_p[k]  <= dl1_p[k-1];
      end
    end
  end

  // cross(up, n): products, then rounded difference
  logic signed [49:0]       pa1 [3], pb1 [3];
  logic signed [VAL_W-1:0]  ux1 [3], px1 [3], ux2 [3], px2 [3];
  logic signed [NQ_W-1:0]   nx1 [3], nx2 [3];
  logic signed [NORM_W-1:0] t2 [3];
  logic signed [51:0]       tw [3];

  for (genvar i = 0; i < 3; i++) begin : g_trnd
    assign tw[i] = (52'(pa1[i]) - 52'(pb1[i]) + 52'sd32768) >>> 16;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pa1[i] <= dl1_up[NORM_LAT-1][(i+1)%3] * n1[(i+2)%3];
        pb1[i] <= dl1_up[NORM_LAT-1][(i+2)%3] * n1[(i+1)%3];
        t2[i]  <= tw[i][NORM_W-1:0];
      end
      ux1 <= dl1_up[NORM_LAT-1];
      px1 <= dl1_p[NORM_LAT-1];
      nx1 <= n1;
      ux2 <= ux1;
      px2 <= px1;
      nx2 <= nx1;
    end
  end

  // second normaliser: right vector for world alignment
  logic signed [NQ_W-1:0]   r2 [3];
  logic signed [VAL_W-1:0]  dl2_up [NORM_LAT][3];
  logic signed [VAL_W-1:0]  dl2_p  [NORM_LAT][3];
  logic signed [NQ_W-1:0]   dl2_n  [NORM_LAT][3];
  logic signed [NORM_W-1:0] dl2_t  [NORM_LAT][3];

  bbt_norm u_norm_right (
    .clk (clk),
    .en  (en),
    .v   (t2),
    .o   (r2)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      dl2_up[0] <= ux2;
      dl2_p[0]  <= px2;
      dl2_n[0]  <= nx2;
      dl2_t[0]  <= t2;
      for (int k = 1; k < NORM_LAT; k++) begin
        dl2_up[k] <= dl2_up[k-1];
        dl2_p[k]  <= dl2_p[k-1];
        dl2_n[k]  <= dl2_n[k-1];
        dl2_t[k]  <= dl2_t[k-1];
      end
    end
  end

  // cross(n, r) for recomputed up, then column select per mode
  logic signed [35:0]       qa [3], qb [3];
  logic signed [VAL_W-1:0]  ux3 [3], px3 [3], px4 [3];
  logic signed [NQ_W-1:0]   nx3 [3], rx3 [3];
  logic signed [NORM_W-1:0] tx3 [3];
  logic signed [37:0]       uw [3];
  logic signed [VAL_W-1:0]  rs4 [3], us4 [3], ns4 [3];

  for (genvar i = 0; i < 3; i++) begin : g_urnd
    assign uw[i] = (38'(qa[i]) - 38'(qb[i]) + 38'sd32768) >>> 16;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        qa[i] <= dl2_n[NORM_LAT-1][(i+1)%3] * r2[(i+2)%3];
        qb[i] <= dl2_n[NORM_LAT-1][(i+2)%3] * r2[(i+1)%3];
      end
      ux3 <= dl2_up[NORM_LAT-1];
      px3 <= dl2_p[NORM_LAT-1];
      nx3 <= dl2_n[NORM_LAT-1];
      tx3 <= dl2_t[NORM_LAT-1];
      rx3 <= r2;
      px4 <= px3;
      for (int i = 0; i < 3; i++) ns4[i] <= VAL_W'(nx3[i]);
      case (align_mode)
        MODE_SCREEN: begin
          for (int i = 0; i < 3; i++) begin
            rs4[i] <= sat32(48'(tx3[i]));
            us4[i] <= ux3[i];
          end
        end
        MODE_WORLD: begin
          for (int i = 0; i < 3; i++) begin
            rs4[i] <= VAL_W'(rx3[i]);
            us4[i] <= sat32(48'(uw[i]));
          end
        end
        MODE_AXIS: begin
          rs4[0] <= VAL_W'(nx3[2]);
          rs4[1] <= '0;
          rs4[2] <= -VAL_W'(nx3[0]);
          us4[0] <= '0;
          us4[1] <= Q_ONE;
          us4[2] <= '0;
        end
        default: begin
          rs4 <= '{default: '0};
          us4 <= '{default: '0};
        end
      endcase
    end
  end

  // scale products, then round and saturate into the output register (identity columns in identity mode)
  logic signed [63:0]      mr [3], mu [3], mn [3];
  logic signed [VAL_W-1:0] px5 [3];
  logic signed [VAL_W-1:0] o_r [3], o_u [3], o_n [3], o_t [3];

  function automatic logic signed [VAL_W-1:0] rnd_sat(input logic signed [63:0] v);
    logic signed [63:0] s;
    s = (v + 64'sd32768) >>> 16;
    return sat32(s[47:0]);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mr[i] <= rs4[i] * scale_x;
        mu[i] <= us4[i] * scale_y;
        mn[i] <= ns4[i] * scale_z;
      end
      px5 <= px4;
      if (align_mode == MODE_IDENT) begin
        o_r <= '{Q_ONE, '0, '0};
        o_u <= '{'0, Q_ONE, '0};
        o_n <= '{'0, '0, Q_ONE};
        o_t <= '{default: '0};
      end else begin
        for (int i = 0; i < 3; i++) begin
          o_r[i] <= rnd_sat(mr[i]);
          o_u[i] <= rnd_sat(mu[i]);
          o_n[i] <= rnd_sat(mn[i]);
        end
        o_t <= px5;
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_out
    assign m_tdata[32*i +: 32]       = o_r[i];
    assign m_tdata[96 + 32*i +: 32]  = o_u[i];
    assign m_tdata[192 + 32*i +: 32] = o_n[i];
    assign m_tdata[288 + 32*i +: 32] = o_t[i];
  end

  // checks
  a_ident: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && align_mode == MODE_IDENT |-> m_tdata[31:0] == Q_ONE)
    else $error("identity right column wrong");

  a_axis_flat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && align_mode == MODE_AXIS |-> m_tdata[63:32] == '0 && m_tdata[255:224] == '0)
    else $error("axis mode left a vertical component");

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule
